[design/wfa_pkg.sv]
`timescale 1ns / 1ps

package wfa_pkg;

  // Default sizing of the block table.
  localparam int DEF_NUM_BLOCKS = 64;
  localparam int DEF_SIZE_BITS  = 32;

  // Fixed field widths of the item interfaces.
  localparam int OP_W     = 1;
  localparam int BLKIDX_W = 6;
  localparam int SIZE_W   = 32;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 7;

  // Value of the active block count after reset.
  localparam logic [CFG_W-1:0] CFG_NUM_BLOCKS_RST = 7'd64;

  // Operation codes of an input item.
  localparam logic [OP_W-1:0] OP_LOAD    = 1'b0;
  localparam logic [OP_W-1:0] OP_REQUEST = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_LOADED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ALLOC  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NONE   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;     // capture the input item and restart the scan
    logic clr_wr;    // write zero at the counter address and advance
    logic load_wr;   // write the loaded size and form the load result
    logic rd_issue;  // read the table at the counter address and advance
    logic upd_wr;    // write back the reduced size and form the result
    logic out_load;  // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_end;    // scan counter reached the active block count
    logic clr_last;  // clearing pass is at the last table entry
  } stat_t;

endpackage

[design/worst_fit_block_allocator.sv]
`timescale 1ns / 1ps
// A load result forms in the load step, a request result after the scan, drain and update steps;
// the scan reads N blocks, the active block count saturated at NUM_BLOCKS, one block per cycle.
// One item is handled at a time: the input stalls until the result enters the output register;
// the next item is taken while a result waits in the output register.
// After reset a clearing pass zeroes the table with input stalled;
// configuration writes are taken at any time.
module worst_fit_block_allocator #(
  parameter int NUM_BLOCKS = wfa_pkg::DEF_NUM_BLOCKS,
  parameter int SIZE_BITS  = wfa_pkg::DEF_SIZE_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [wfa_pkg::OP_W-1:0]        in_op,
  input  logic [wfa_pkg::BLKIDX_W-1:0]    in_block_index,
  input  logic [wfa_pkg::SIZE_W-1:0]      in_size,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [wfa_pkg::STATUS_W-1:0]    out_status,
  output logic [wfa_pkg::BLKIDX_W-1:0]    out_chosen_block,
  output logic [wfa_pkg::SIZE_W-1:0]      out_remaining_size,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wfa_pkg::CFG_W-1:0]       cfg_data
);

  wfa_pkg::cmd_t  cmd;
  wfa_pkg::stat_t st;

  // The count register is always writable.
  assign cfg_ready = 1'b1;

  wfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  wfa_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_block_index     (in_block_index),
    .in_size            (in_size),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_data           (cfg_data),
    .out_status         (out_status),
    .out_chosen_block   (out_chosen_block),
    .out_remaining_size (out_remaining_size)
  );

endmodule

[design/wfa_ctrl.sv]
`timescale 1ns / 1ps

module wfa_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [wfa_pkg::OP_W-1:0]      in_op,
  output logic                          in_stall,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  wfa_pkg::stat_t                st,
  output wfa_pkg::cmd_t                 cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_UPDATE,
    S_FINISH
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   in_acc;
  logic   slot_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // Decode the datapath commands from the current state.
  always_comb begin
    cmd          = '0;
    cmd.latch    = in_acc;
    cmd.clr_wr   = (state_r == S_CLEAR);
    cmd.load_wr  = (state_r == S_LOAD);
    cmd.rd_issue = (state_r == S_SCAN) && !st.at_end;
    cmd.upd_wr   = (state_r == S_UPDATE);
    cmd.out_load = (state_r == S_FINISH) && slot_free;
  end

  // State sequencing and the output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          if (st.clr_last) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            state_r <= (in_op == wfa_pkg::OP_REQUEST) ? S_SCAN : S_LOAD;
          end
        end
        S_LOAD:   state_r <= S_FINISH;
        S_SCAN: begin
          if (st.at_end) state_r <= S_DRAIN;
        end
        S_DRAIN:  state_r <= S_UPDATE;
        S_UPDATE: state_r <= S_FINISH;
        S_FINISH: begin
          if (slot_free) state_r <= S_IDLE;
        end
        default:  state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // An accepted item always blocks the input until its result is formed.
  a_acc_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input not blocked after accepting an item");

  // The output register is only overwritten when it is empty or being taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.out_load)
    else $error("pending result overwritten");

  // A new result appears only from the finishing step.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result raised outside the finishing step");

  // The scan never reads past the active block count.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> !st.at_end)
    else $error("table read beyond the active block count");
`endif

endmodule

[design/wfa_datapath.sv]
`timescale 1ns / 1ps

module wfa_datapath #(
  parameter int NUM_BLOCKS = wfa_pkg::DEF_NUM_BLOCKS,
  parameter int SIZE_BITS  = wfa_pkg::DEF_SIZE_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wfa_pkg::cmd_t                   cmd,
  output wfa_pkg::stat_t                  st,
  input  logic [wfa_pkg::BLKIDX_W-1:0]    in_block_index,
  input  logic [wfa_pkg::SIZE_W-1:0]      in_size,
  input  logic                            cfg_we,
  input  logic [wfa_pkg::CFG_W-1:0]       cfg_data,
  output logic [wfa_pkg::STATUS_W-1:0]    out_status,
  output logic [wfa_pkg::BLKIDX_W-1:0]    out_chosen_block,
  output logic [wfa_pkg::SIZE_W-1:0]      out_remaining_size
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int LIM_W = (CNT_W > wfa_pkg::CFG_W) ? CNT_W : wfa_pkg::CFG_W;
  localparam int EXT_W = (SIZE_BITS > wfa_pkg::SIZE_W) ? SIZE_BITS : wfa_pkg::SIZE_W;
  localparam int CMP_W = 32;

  // Free size table.
  logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];
  logic [SIZE_BITS-1:0] rd_data_r;

  logic [CNT_W-1:0]                  cnt_r;
  logic                              pend_vld_r;
  logic [IDX_W-1:0]                  pend_idx_r;
  logic [wfa_pkg::BLKIDX_W-1:0]      idx_r;
  logic [SIZE_BITS-1:0]              sz_r;
  logic                              found_r;
  logic [SIZE_BITS-1:0]              best_val_r;
  logic [IDX_W-1:0]                  best_idx_r;
  logic [wfa_pkg::STATUS_W-1:0]      res_status_r;
  logic [wfa_pkg::BLKIDX_W-1:0]      res_blk_r;
  logic [SIZE_BITS-1:0]              res_rem_r;
  logic [wfa_pkg::STATUS_W-1:0]      out_status_r;
  logic [wfa_pkg::BLKIDX_W-1:0]      out_blk_r;
  logic [wfa_pkg::SIZE_W-1:0]        out_rem_r;
  logic [wfa_pkg::CFG_W-1:0]         num_blocks_r;

  logic [EXT_W-1:0]     sz_ext;
  logic [EXT_W-1:0]     rem_ext;
  logic [SIZE_BITS-1:0] sz_in;
  logic [LIM_W-1:0]     lim;
  logic                 idx_ok;
  logic                 fits;
  logic                 better;
  logic [SIZE_BITS-1:0] diff;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [SIZE_BITS-1:0] mem_wdata;

  // Input size masked or extended to the table width.
  assign sz_ext = EXT_W'(in_size);
  assign sz_in  = sz_ext[SIZE_BITS-1:0];

  // Scan limit saturates at the table depth.
  always_comb begin
    if (LIM_W'(num_blocks_r) > LIM_W'(NUM_BLOCKS)) begin
      lim = LIM_W'(NUM_BLOCKS);
    end else begin
      lim = LIM_W'(num_blocks_r);
    end
  end

  assign st.at_end   = (LIM_W'(cnt_r) == lim);
  assign st.clr_last = (cnt_r == CNT_W'(NUM_BLOCKS - 1));

  assign idx_ok = (CMP_W'(idx_r) < CMP_W'(NUM_BLOCKS));
  assign fits   = (rd_data_r >= sz_r);
  assign better = !found_r || (rd_data_r > best_val_r);
  assign diff   = best_val_r - sz_r;

  // Table write port shared by clearing, loading and write-back.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r[IDX_W-1:0];
    mem_wdata = '0;
    if (cmd.clr_wr) begin
      mem_we = 1'b1;
    end else if (cmd.load_wr) begin
      mem_we    = idx_ok;
      mem_waddr = IDX_W'(idx_r);
      mem_wdata = sz_r;
    end else if (cmd.upd_wr) begin
      mem_we    = found_r;
      mem_waddr = best_idx_r;
      mem_wdata = diff;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.rd_issue) rd_data_r <= mem[cnt_r[IDX_W-1:0]];
  end

  // Control registers: counter, read tracking, best flag, configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      pend_vld_r   <= 1'b0;
      found_r      <= 1'b0;
      num_blocks_r <= wfa_pkg::CFG_NUM_BLOCKS_RST;
    end else begin
      if (cfg_we) num_blocks_r <= cfg_data;
      if (cmd.latch) begin
        cnt_r <= '0;
      end else if (cmd.clr_wr || cmd.rd_issue) begin
        cnt_r <= cnt_r + 1'b1;
      end
      pend_vld_r <= cmd.rd_issue;
      if (cmd.latch) begin
        found_r <= 1'b0;
      end else if (pend_vld_r && fits && better) begin
        found_r <= 1'b1;
      end
    end
  end

  // Payload registers: item fields, best candidate, result and output.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      idx_r <= in_block_index;
      sz_r  <= sz_in;
    end
    if (cmd.rd_issue) pend_idx_r <= cnt_r[IDX_W-1:0];
    if (!cmd.latch && pend_vld_r && fits && better) begin
      best_val_r <= rd_data_r;
      best_idx_r <= pend_idx_r;
    end
    if (cmd.load_wr) begin
      res_status_r <= wfa_pkg::STATUS_LOADED;
      res_blk_r    <= idx_r;
      res_rem_r    <= idx_ok ? sz_r : '0;
    end else if (cmd.upd_wr) begin
      if (found_r) begin
        res_status_r <= wfa_pkg::STATUS_ALLOC;
        res_blk_r    <= wfa_pkg::BLKIDX_W'(best_idx_r);
        res_rem_r    <= diff;
      end else begin
        res_status_r <= wfa_pkg::STATUS_NONE;
        res_blk_r    <= '0;
        res_rem_r    <= '0;
      end
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_blk_r    <= res_blk_r;
      out_rem_r    <= rem_ext[wfa_pkg::SIZE_W-1:0];
    end
  end

  assign rem_ext            = EXT_W'(res_rem_r);
  assign out_status         = out_status_r;
  assign out_chosen_block   = out_blk_r;
  assign out_remaining_size = out_rem_r;

endmodule

[verif/worst_fit_block_allocator_tb.sv]
`timescale 1ns / 1ps

module worst_fit_block_allocator_tb;

  localparam int TABLE_DEPTH = wfa_pkg::DEF_NUM_BLOCKS;
  localparam int PHASES      = 11;
  localparam int PHASE_ITEMS = 95;

  // One expected result item.
  typedef struct {
    logic [wfa_pkg::STATUS_W-1:0] status;
    logic [wfa_pkg::BLKIDX_W-1:0] chosen_block;
    logic [wfa_pkg::SIZE_W-1:0]   remaining_size;
  } alloc_result_t;

  // Mirrors the free-size table, predicts each result and checks it in order.
  class alloc_scoreboard;
    logic [wfa_pkg::SIZE_W-1:0] free_size [TABLE_DEPTH];
    logic [wfa_pkg::CFG_W-1:0]  block_count;
    alloc_result_t              pending_results[$];
    int                         errors;

    function new();
      foreach (free_size[i]) free_size[i] = '0;
      block_count = wfa_pkg::CFG_NUM_BLOCKS_RST;
      errors = 0;
    endfunction

    function void set_block_count(logic [wfa_pkg::CFG_W-1:0] value);
      block_count = value;
    endfunction

    function int scan_limit();
      return (block_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(block_count);
    endfunction

    // Predict the result of an accepted item and update the table copy.
    function void note_item(logic [wfa_pkg::OP_W-1:0] op,
                            logic [wfa_pkg::BLKIDX_W-1:0] idx,
                            logic [wfa_pkg::SIZE_W-1:0] sz);
      int            limit;
      int            best;
      bit            found;
      alloc_result_t r;
      if (op == wfa_pkg::OP_LOAD) begin
        r.status = wfa_pkg::STATUS_LOADED;
        r.chosen_block = idx;
        if (idx < TABLE_DEPTH) begin
          free_size[idx] = sz;
          r.remaining_size = sz;
        end else begin
          r.remaining_size = '0;
        end
      end else begin
        limit = scan_limit();
        best = 0;
        found = 1'b0;
        // Largest fitting block wins; strict compare keeps the lowest index on ties.
        for (int j = 0; j < limit; j++) begin
          if (free_size[j] >= sz && (!found || free_size[j] > free_size[best])) begin
            best = j;
            found = 1'b1;
          end
        end
        if (!found) begin
          r.status = wfa_pkg::STATUS_NONE;
          r.chosen_block = '0;
          r.remaining_size = '0;
        end else begin
          free_size[best] = free_size[best] - sz;
          r.status = wfa_pkg::STATUS_ALLOC;
          r.chosen_block = best[wfa_pkg::BLKIDX_W-1:0];
          r.remaining_size = free_size[best];
        end
      end
      pending_results.push_back(r);
    endfunction

    // Compare one accepted result item with the oldest prediction.
    function void check_result(logic [wfa_pkg::STATUS_W-1:0] status,
                               logic [wfa_pkg::BLKIDX_W-1:0] chosen_block,
                               logic [wfa_pkg::SIZE_W-1:0] remaining_size);
      alloc_result_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result item: status %0d, chosen_block %0d, remaining_size %0h",
               status, chosen_block, remaining_size);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        errors++;
      end
      if (chosen_block !== e.chosen_block) begin
        $error("chosen_block: expected %0d, got %0d", e.chosen_block, chosen_block);
        errors++;
      end
      if (remaining_size !== e.remaining_size) begin
        $error("remaining_size: expected %0h, got %0h", e.remaining_size, remaining_size);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [wfa_pkg::OP_W-1:0]     in_op = wfa_pkg::OP_LOAD;
  logic [wfa_pkg::BLKIDX_W-1:0] in_block_index = '0;
  logic [wfa_pkg::SIZE_W-1:0]   in_size = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [wfa_pkg::STATUS_W-1:0] out_status;
  logic [wfa_pkg::BLKIDX_W-1:0] out_chosen_block;
  logic [wfa_pkg::SIZE_W-1:0]   out_remaining_size;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [wfa_pkg::CFG_W-1:0]    cfg_data = '0;

  alloc_scoreboard sb;
  int              in_gap_pct = 20;
  int              out_stall_pct = 20;
  bit              calm = 1'b0;
  int              stall_left = 0;

  worst_fit_block_allocator dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_block_index     (in_block_index),
    .in_size            (in_size),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_chosen_block   (out_chosen_block),
    .out_remaining_size (out_remaining_size),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  // Clock generation.
  initial begin
    forever #2 clk = ~clk;
  end

  // Watch all three handshakes and feed the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_block_count(cfg_data);
      if (in_valid && !in_stall) sb.note_item(in_op, in_block_index, in_size);
      if (out_valid && !out_stall) sb.check_result(out_status, out_chosen_block,
                                                   out_remaining_size);
    end
  end

  // Result-side backpressure in random bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(99) < out_stall_pct) begin
      stall_left <= $urandom_range(17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one item, maybe after an idle burst, and return once it is accepted.
  task automatic send_item(logic [wfa_pkg::OP_W-1:0] op,
                           logic [wfa_pkg::BLKIDX_W-1:0] idx,
                           logic [wfa_pkg::SIZE_W-1:0] sz);
    if (!calm && $urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_block_index <= idx;
    in_size <= sz;
    do @(posedge clk); while (in_stall);
  endtask

  // Change the active block count once every predicted result has come back.
  task automatic write_block_count(logic [wfa_pkg::CFG_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Free sizes drawn from a range chosen per phase.
  function automatic logic [wfa_pkg::SIZE_W-1:0] pick_size(int scale);
    case (scale)
      0: return $urandom_range(0, 15);
      1: return $urandom_range(0, 65535);
      2: return $urandom;
      default: begin
        case ($urandom_range(3))
          0: return '0;
          1: return '1;
          2: return 32'h8000_0000;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // Request sizes steered by the table copy so that many of them fit.
  function automatic logic [wfa_pkg::SIZE_W-1:0] pick_request(int scale);
    int lim;
    int j;
    int r;
    lim = sb.scan_limit();
    j = (lim == 0) ? $urandom_range(0, TABLE_DEPTH - 1) : $urandom_range(0, lim - 1);
    r = $urandom_range(99);
    if (r < 55) return $urandom_range(0, sb.free_size[j]);
    else if (r < 65) return sb.free_size[j];
    else if (r < 75) return sb.free_size[j] + 1;
    else if (r < 80) return '0;
    else if (r < 85) return '1;
    else return pick_size(scale);
  endfunction

  // Run timeout.
  initial begin
    #2_000_000;
    $display("worst_fit_block_allocator: mismatch");
    $finish;
  end

  // Main stimulus.
  initial begin
    int scan_settings [PHASES];
    int pct_choices [4];
    int lim;
    int n_loads;
    int scale;
    logic [wfa_pkg::BLKIDX_W-1:0] idx;

    scan_settings = '{64, 1, 127, 8, 0, 65, 3, 63, 16, 2, 64};
    pct_choices = '{0, 10, 30, 60};
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, size extremes, ties and zero-size requests.
    send_item(wfa_pkg::OP_REQUEST, 6'd0, 32'd0);
    send_item(wfa_pkg::OP_REQUEST, 6'd17, 32'd1);
    send_item(wfa_pkg::OP_LOAD, 6'd0, 32'hFFFF_FFFF);
    send_item(wfa_pkg::OP_LOAD, 6'd63, 32'hFFFF_FFFF);
    send_item(wfa_pkg::OP_LOAD, 6'd5, 32'd0);
    send_item(wfa_pkg::OP_LOAD, 6'd32, 32'h8000_0000);
    send_item(wfa_pkg::OP_LOAD, 6'd10, 32'd1);
    send_item(wfa_pkg::OP_REQUEST, 6'd63, 32'd0);
    send_item(wfa_pkg::OP_REQUEST, 6'd0, 32'hFFFF_FFFF);
    send_item(wfa_pkg::OP_REQUEST, 6'd0, 32'hFFFF_FFFF);
    send_item(wfa_pkg::OP_REQUEST, 6'd42, 32'h8000_0000);
    send_item(wfa_pkg::OP_REQUEST, 6'd0, 32'd1);
    send_item(wfa_pkg::OP_REQUEST, 6'd0, 32'd1);
    send_item(wfa_pkg::OP_LOAD, 6'd63, 32'h7FFF_FFFF);
    send_item(wfa_pkg::OP_LOAD, 6'd62, 32'h7FFF_FFFF);
    send_item(wfa_pkg::OP_REQUEST, 6'd21, 32'h10);

    // Directed: a single-block scan.
    write_block_count(7'd1);
    send_item(wfa_pkg::OP_REQUEST, 6'd0, 32'd0);
    send_item(wfa_pkg::OP_LOAD, 6'd0, 32'd100);
    send_item(wfa_pkg::OP_LOAD, 6'd1, 32'd1000);
    send_item(wfa_pkg::OP_REQUEST, 6'd0, 32'd50);
    send_item(wfa_pkg::OP_REQUEST, 6'd0, 32'd60);

    // Directed: an empty scan, then a count above the table size.
    write_block_count(7'd0);
    send_item(wfa_pkg::OP_REQUEST, 6'd0, 32'd0);
    send_item(wfa_pkg::OP_LOAD, 6'd3, 32'd5);
    write_block_count(7'd127);
    send_item(wfa_pkg::OP_REQUEST, 6'd0, 32'd1);

    // Random phases, each with its own block count, size range and idling.
    scan_settings[9] = $urandom_range(0, 127);
    for (int p = 0; p < PHASES; p++) begin
      write_block_count(scan_settings[p][wfa_pkg::CFG_W-1:0]);
      calm = (p == PHASES - 1);
      in_gap_pct = pct_choices[$urandom_range(3)];
      out_stall_pct = pct_choices[$urandom_range(3)];
      scale = $urandom_range(3);
      lim = sb.scan_limit();
      n_loads = (lim == 0) ? 4 : ((lim < 24) ? lim : 24);

      // Fill the scanned part of the table first.
      for (int k = 0; k < n_loads; k++) begin
        idx = (lim == 0) ? wfa_pkg::BLKIDX_W'($urandom_range(0, TABLE_DEPTH - 1))
                         : wfa_pkg::BLKIDX_W'($urandom_range(0, lim - 1));
        send_item(wfa_pkg::OP_LOAD, idx, pick_size(scale));
      end

      // Then a mix of requests and reloads.
      for (int k = n_loads; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(99) < 60) begin
          send_item(wfa_pkg::OP_REQUEST,
                    wfa_pkg::BLKIDX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                    pick_request(scale));
        end else begin
          if (lim != 0 && $urandom_range(99) < 85) begin
            idx = wfa_pkg::BLKIDX_W'($urandom_range(0, lim - 1));
          end else begin
            idx = wfa_pkg::BLKIDX_W'($urandom_range(0, TABLE_DEPTH - 1));
          end
          send_item(wfa_pkg::OP_LOAD, idx, pick_size(scale));
        end
      end
    end

    // Drain the remaining results and give the block time to misbehave.
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("worst_fit_block_allocator: match");
    end else begin
      $display("worst_fit_block_allocator: mismatch");
    end
    $finish;
  end

endmodule
